@@ sv/gbf_pkg.sv @@
// gbf_pkg: shared types and constants of the rotated grid fusion block.
// Depends on nothing; imported by grid_bayes_fusion_rotated.
`default_nettype none

package gbf_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_OFFSET,
        ST_ROT_A,
        ST_ROT_B,
        ST_ROT_C,
        ST_DIV_LOAD,
        ST_DIV,
        ST_CHECK,
        ST_READ,
        ST_WEIGH,
        ST_ODDS_A,
        ST_ODDS_B,
        ST_POST_LOAD,
        ST_POST,
        ST_DONE
    } state_t;

    // Register indexes of the configuration port
    localparam logic [2:0] REG_CENTER_X    = 3'd0;
    localparam logic [2:0] REG_CENTER_Y    = 3'd1;
    localparam logic [2:0] REG_COS_HEADING = 3'd2;
    localparam logic [2:0] REG_SIN_HEADING = 3'd3;
    localparam logic [2:0] REG_CELL_SIZE   = 3'd4;
    localparam logic [2:0] REG_PRIOR_WT    = 3'd5;
    localparam logic [2:0] REG_NEW_WT      = 3'd6;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 24;

    // Stored probability after reset (about 0.001 in Q0.16)
    localparam logic [15:0] GRID_RESET = 16'd66;
    localparam logic [15:0] PROB_MAX   = 16'hFFFF;

    // Doubled local offset (2*col - LOCAL_SIZE), enough for LOCAL_SIZE <= 1024
    localparam int OFF_W = 12;
    // Rotated coordinate scaled by 2^15
    localparam int NX_W  = 48;
    // Magnitude of a coordinate after the shift by 15, quotient width
    localparam int QW    = NX_W - 15;

endpackage

`default_nettype wire

@@ sv/grid_bayes_fusion_rotated.sv @@
// grid_bayes_fusion_rotated: maps a local grid cell into the global map and
// fuses its probability into the stored one. Uses gbf_pkg.
`default_nettype none

// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_stall   cell_col, cell_row, cell_prob
// out      out  out_valid / out_stall in_map, target_col, target_row, posterior
// cfg      in   cfg_wr_en             cfg_index, cfg_data
//
// A word passes the offset and rotation steps and the two coordinate dividers, which
// retire one quotient bit a cycle, then the posterior divider, 17 bits, around one
// read-modify-write of the grid memory; the next word is taken only after its result
// is loaded. A word that lands outside the map skips the fusion.
// After reset a clearing pass writes every grid entry; no word is taken meanwhile.
// The result sits in an output register, so a stalled result holds only the
// next word's last cycle.

module grid_bayes_fusion_rotated #(
    parameter int LOCAL_SIZE  = 128,
    parameter int GLOBAL_SIZE = 256
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [gbf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gbf_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [6:0]                    cell_col,
    input  wire logic [6:0]                    cell_row,
    input  wire logic [15:0]                   cell_prob,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic                               in_map,
    output logic [7:0]                         target_col,
    output logic [7:0]                         target_row,
    output logic [15:0]                        posterior
);

    import gbf_pkg::*;

    localparam int CELLS  = GLOBAL_SIZE * GLOBAL_SIZE;
    localparam int AW     = $clog2(CELLS);
    localparam int GI_W   = $clog2(GLOBAL_SIZE);
    localparam int CNT_W  = $clog2(QW + 1);
    localparam int EX_W   = OFF_W + 17;
    localparam int MP_W   = EX_W + 16;

    // Weighted probability rounded to Q0.16, result in [1, 65535]
    function automatic logic [16:0] weigh(input logic [15:0] p, input logic [15:0] w);
        logic signed [16:0] dev;
        logic signed [34:0] acc;
        begin
            dev = $signed({1'b0, p}) - 17'sd32768;
            acc = 35'sd2147483648 + dev * $signed({1'b0, w}) + 35'sd32768;
            weigh = acc[32:16];
        end
    endfunction

    // Configuration registers
    logic signed [23:0] cx_reg, cy_reg;
    logic signed [15:0] cos_reg, sin_reg;
    logic [15:0]        cs_reg, pw_reg, nw_reg;

    // Sequencer and datapath registers
    state_t                state_reg, state_next;
    logic [AW-1:0]         clr_reg;
    logic [6:0]            col_reg, row_reg;
    logic [15:0]           prob_reg;
    logic signed [EX_W-1:0] ex_reg, ey_reg;
    logic signed [MP_W-1:0] m0_reg, m1_reg, m2_reg, m3_reg;
    logic signed [NX_W-1:0] nx_reg, ny_reg;
    logic [QW-1:0]         qx_reg, qy_reg;
    logic [15:0]           rx_reg, ry_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  hit_reg;
    logic [AW-1:0]         addr_reg;
    logic [15:0]           rd_reg;
    logic [16:0]           wp_reg, wn_reg;
    logic [33:0]           num_reg;
    logic [34:0]           den_reg;
    logic [34:0]           rem_reg;
    logic [16:0]           pq_reg;
    logic [15:0]           post_reg;
    logic                  out_valid_reg;
    logic                  in_map_reg;
    logic [7:0]            tcol_reg, trow_reg;
    logic [15:0]           post_out_reg;

    logic [15:0] grid_mem [CELLS];

    // Derived signals
    logic [15:0]          cs_eff;
    logic                 in_acc, out_load, div_last, post_last, clr_last;
    logic                 x_ok, y_ok;
    logic [16:0]          shx, shy;
    logic [35:0]          shp;
    logic [50:0]          post_dvd;
    logic signed [NX_W-1:0] nx_mag, ny_mag;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [15:0]          mem_wdata;

    assign cs_eff    = (cs_reg == 16'd0) ? 16'd1 : cs_reg;
    assign in_acc    = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);
    assign div_last  = (cnt_reg == CNT_W'(QW - 1));
    assign post_last = (cnt_reg == CNT_W'(16));
    assign clr_last  = (clr_reg == AW'(CELLS - 1));
    assign x_ok      = (!nx_reg[NX_W-1] || qx_reg == '0) && (qx_reg < QW'(GLOBAL_SIZE));
    assign y_ok      = (!ny_reg[NX_W-1] || qy_reg == '0) && (qy_reg < QW'(GLOBAL_SIZE));
    assign shx       = {rx_reg, qx_reg[QW-1]};
    assign shy       = {ry_reg, qy_reg[QW-1]};
    assign shp       = {rem_reg, pq_reg[16]};
    assign post_dvd  = {1'b0, num_reg, 16'd0} + 51'(den_reg >> 1);
    assign nx_mag    = nx_reg[NX_W-1] ? -nx_reg : nx_reg;
    assign ny_mag    = ny_reg[NX_W-1] ? -ny_reg : ny_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            cos_reg <= 16'sd16384;
            sin_reg <= '0;
            cs_reg  <= 16'd10;
            pw_reg  <= '0;
            nw_reg  <= 16'd58982;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_CENTER_X:    cx_reg  <= $signed(cfg_data);
                REG_CENTER_Y:    cy_reg  <= $signed(cfg_data);
                REG_COS_HEADING: cos_reg <= $signed(cfg_data[15:0]);
                REG_SIN_HEADING: sin_reg <= $signed(cfg_data[15:0]);
                REG_CELL_SIZE:   cs_reg  <= cfg_data[15:0];
                REG_PRIOR_WT:    pw_reg  <= cfg_data[15:0];
                REG_NEW_WT:      nw_reg  <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (clr_last) state_next = ST_IDLE;
            ST_IDLE:      if (in_acc) state_next = ST_OFFSET;
            ST_OFFSET:    state_next = ST_ROT_A;
            ST_ROT_A:     state_next = ST_ROT_B;
            ST_ROT_B:     state_next = ST_ROT_C;
            ST_ROT_C:     state_next = ST_DIV_LOAD;
            ST_DIV_LOAD:  state_next = ST_DIV;
            ST_DIV:       if (div_last) state_next = ST_CHECK;
            ST_CHECK:     state_next = (x_ok && y_ok) ? ST_READ : ST_DONE;
            ST_READ:      state_next = ST_WEIGH;
            ST_WEIGH:     state_next = ST_ODDS_A;
            ST_ODDS_A:    state_next = ST_ODDS_B;
            ST_ODDS_B:    state_next = ST_POST_LOAD;
            ST_POST_LOAD: state_next = ST_POST;
            ST_POST:      if (post_last) state_next = ST_DONE;
            ST_DONE:      if (out_load) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = post_reg;
        unique case (state_reg)
            ST_IDLE:  in_stall = 1'b0;
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = GRID_RESET;
            end
            ST_DONE:  mem_we = hit_reg && out_load;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + AW'(1);
        end
    end

    // Grid memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_waddr] <= mem_wdata;
        if (state_reg == ST_READ)
            rd_reg <= grid_mem[addr_reg];
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                col_reg  <= cell_col;
                row_reg  <= cell_row;
                prob_reg <= cell_prob;
            end
            // doubled offset from the local grid center, in length units
            ST_OFFSET:
            begin
                ex_reg <= ($signed({4'd0, col_reg, 1'b0}) - $signed(OFF_W'(LOCAL_SIZE)))
                          * $signed({1'b0, cs_eff});
                ey_reg <= ($signed({4'd0, row_reg, 1'b0}) - $signed(OFF_W'(LOCAL_SIZE)))
                          * $signed({1'b0, cs_eff});
            end
            ST_ROT_A:
            begin
                m0_reg <= ex_reg * cos_reg;
                m1_reg <= ey_reg * sin_reg;
            end
            ST_ROT_B:
            begin
                m2_reg <= ex_reg * sin_reg;
                m3_reg <= ey_reg * cos_reg;
                nx_reg <= (NX_W'(cx_reg) <<< 15) + NX_W'(m0_reg) - NX_W'(m1_reg);
            end
            ST_ROT_C:
                ny_reg <= (NX_W'(cy_reg) <<< 15) + NX_W'(m2_reg) + NX_W'(m3_reg);
            // truncating divide of |n| >> 15 by the cell size, a bit a cycle
            ST_DIV_LOAD:
            begin
                qx_reg  <= nx_mag[NX_W-1:15];
                qy_reg  <= ny_mag[NX_W-1:15];
                rx_reg  <= '0;
                ry_reg  <= '0;
                cnt_reg <= '0;
            end
            ST_DIV:
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (shx >= {1'b0, cs_eff})
                begin
                    rx_reg <= 16'(shx - {1'b0, cs_eff});
                    qx_reg <= {qx_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rx_reg <= shx[15:0];
                    qx_reg <= {qx_reg[QW-2:0], 1'b0};
                end
                if (shy >= {1'b0, cs_eff})
                begin
                    ry_reg <= 16'(shy - {1'b0, cs_eff});
                    qy_reg <= {qy_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    ry_reg <= shy[15:0];
                    qy_reg <= {qy_reg[QW-2:0], 1'b0};
                end
            end
            ST_CHECK:
            begin
                hit_reg  <= x_ok && y_ok;
                addr_reg <= AW'(AW'(qy_reg[GI_W-1:0]) * AW'(GLOBAL_SIZE))
                            + AW'(qx_reg[GI_W-1:0]);
                wn_reg   <= weigh(prob_reg, nw_reg);
                post_reg <= '0;
            end
            ST_WEIGH:
                wp_reg <= weigh(rd_reg, pw_reg);
            ST_ODDS_A:
                num_reg <= wp_reg * wn_reg;
            ST_ODDS_B:
                den_reg <= 35'(num_reg) + 35'(34'(17'h10000 - wp_reg)
                                              * 34'(17'h10000 - wn_reg));
            // posterior = (num * 2^16 + den / 2) / den, quotient below 2^17
            ST_POST_LOAD:
            begin
                rem_reg <= {1'b0, post_dvd[50:17]};
                pq_reg  <= post_dvd[16:0];
                cnt_reg <= '0;
            end
            ST_POST:
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (shp >= {1'b0, den_reg})
                begin
                    rem_reg <= 35'(shp - {1'b0, den_reg});
                    pq_reg  <= {pq_reg[15:0], 1'b1};
                    if (post_last)
                        post_reg <= pq_reg[15] ? PROB_MAX : {pq_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shp[34:0];
                    pq_reg  <= {pq_reg[15:0], 1'b0};
                    if (post_last)
                        post_reg <= pq_reg[15] ? PROB_MAX : {pq_reg[14:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            in_map_reg   <= hit_reg;
            tcol_reg     <= hit_reg ? 8'(qx_reg) : 8'd0;
            trow_reg     <= hit_reg ? 8'(qy_reg) : 8'd0;
            post_out_reg <= hit_reg ? post_reg : 16'd0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign in_map     = in_map_reg;
    assign target_col = tcol_reg;
    assign target_row = trow_reg;
    assign posterior  = post_out_reg;

endmodule

`default_nettype wire

@@ sim/tb_grid_bayes_fusion_rotated.sv @@
// Testbench for grid_bayes_fusion_rotated: directed cells, then random cells
// under several heading/position settings, checked against a built-in grid model.
// Depends on gbf_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_grid_bayes_fusion_rotated;
    import gbf_pkg::*;

    localparam int  LOCAL_SZ   = 128;
    localparam int  GLOBAL_SZ  = 256;
    localparam int  CYCLE_CAP  = 1000000;
    localparam int  DRAIN_WAIT = 200;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        logic        in_map;
        logic [7:0]  tcol;
        logic [7:0]  trow;
        logic [15:0] post;
    } fusion_t;

    typedef struct packed {
        logic [6:0]  col;
        logic [6:0]  row;
        logic [15:0] prob;
        logic        typed;
        fusion_t     want;
    } cell_row_t;

    localparam fusion_t OFF_MAP = '{1'b0, 8'd0, 8'd0, 16'd0};

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [6:0] cell_col = '0;
    logic [6:0] cell_row = '0;
    logic [15:0] cell_prob = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic in_map;
    logic [7:0] target_col;
    logic [7:0] target_row;
    logic [15:0] posterior;

    grid_bayes_fusion_rotated #(.LOCAL_SIZE(LOCAL_SZ), .GLOBAL_SIZE(GLOBAL_SZ)) u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .cell_col(cell_col), .cell_row(cell_row), .cell_prob(cell_prob),
        .out_valid(out_valid), .out_stall(out_stall),
        .in_map(in_map), .target_col(target_col), .target_row(target_row),
        .posterior(posterior)
    );

    always #4 clk = ~clk;

    // Model copy of the registers and the global map
    logic signed [23:0] m_cx = 24'sd0;
    logic signed [23:0] m_cy = 24'sd0;
    logic signed [15:0] m_cos = 16'sd16384;
    logic signed [15:0] m_sin = 16'sd0;
    logic [15:0] m_csize = 16'd10;
    logic [15:0] m_pw = 16'd0;
    logic [15:0] m_nw = 16'd58982;
    logic [15:0] map_model [0:GLOBAL_SZ*GLOBAL_SZ-1];

    fusion_t pending_updates [$];
    int errs = 0;
    int cycles = 0;
    int burst_left = 0;

    // Directed cells under reset settings (target = col - 64, row - 64)
    cell_row_t dir_tab [0:15] = '{
        '{7'd0,   7'd0,   16'd0,     1'b1, OFF_MAP},
        '{7'd63,  7'd64,  16'd40000, 1'b1, OFF_MAP},
        '{7'd64,  7'd63,  16'd40000, 1'b1, OFF_MAP},
        '{7'd127, 7'd0,   16'd65535, 1'b1, OFF_MAP},
        '{7'd0,   7'd127, 16'd65535, 1'b1, OFF_MAP},
        '{7'd64,  7'd64,  16'd32768, 1'b1, '{1'b1, 8'd0,  8'd0,  16'd32768}},
        '{7'd127, 7'd127, 16'd32768, 1'b1, '{1'b1, 8'd63, 8'd63, 16'd32768}},
        '{7'd127, 7'd127, 16'd65535, 1'b0, OFF_MAP},
        '{7'd127, 7'd127, 16'd0,     1'b0, OFF_MAP},
        '{7'd64,  7'd64,  16'd1,     1'b0, OFF_MAP},
        '{7'd100, 7'd90,  16'hAAAA,  1'b0, OFF_MAP},
        '{7'd85,  7'd106, 16'h5555,  1'b0, OFF_MAP},
        '{7'd106, 7'd85,  16'h00FF,  1'b0, OFF_MAP},
        '{7'd120, 7'd70,  16'hFF00,  1'b0, OFF_MAP},
        '{7'd65,  7'd127, 16'd65534, 1'b0, OFF_MAP},
        '{7'd127, 7'd65,  16'd32767, 1'b0, OFF_MAP}
    };

    // Probability pulled toward one half by a Q0.16 weight, rounded to Q0.16
    function automatic longint unsigned weigh_prob(logic [15:0] p, logic [15:0] w);
        longint a;
        a = 64'sd2147483648 + (longint'(p) - 32768) * longint'(w);
        return longint'(a + 32768) >>> 16;
    endfunction

    // Map one local cell to the global map and fuse it; updates the map model
    function automatic fusion_t fuse_cell(logic [6:0] c, logic [6:0] r, logic [15:0] p);
        longint cs, ex, ey, nx, ny, tx, ty;
        longint unsigned wp, wn, num, d, pst;
        fusion_t f;
        cs = (m_csize == 0) ? 1 : longint'(m_csize);
        ex = (2 * longint'(c) - LOCAL_SZ) * cs;
        ey = (2 * longint'(r) - LOCAL_SZ) * cs;
        nx = longint'(m_cx) * 32768 + ex * longint'(m_cos) - ey * longint'(m_sin);
        ny = longint'(m_cy) * 32768 + ex * longint'(m_sin) + ey * longint'(m_cos);
        tx = nx / (32768 * cs);
        ty = ny / (32768 * cs);
        if (tx < 0 || tx >= GLOBAL_SZ || ty < 0 || ty >= GLOBAL_SZ)
            return OFF_MAP;
        wp = weigh_prob(map_model[ty * GLOBAL_SZ + tx], m_pw);
        wn = weigh_prob(p, m_nw);
        num = wp * wn;
        d = num + (65536 - wp) * (65536 - wn);
        pst = (num * 65536 + d / 2) / d;
        if (pst > 65535)
            pst = 65535;
        map_model[ty * GLOBAL_SZ + tx] = pst[15:0];
        f.in_map = 1'b1;
        f.tcol = tx[7:0];
        f.trow = ty[7:0];
        f.post = pst[15:0];
        return f;
    endfunction

    // Register write through the plain write port, mirrored into the model
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_CENTER_X:    m_cx = val;
            REG_CENTER_Y:    m_cy = val;
            REG_COS_HEADING: m_cos = val[15:0];
            REG_SIN_HEADING: m_sin = val[15:0];
            REG_CELL_SIZE:   m_csize = val[15:0];
            REG_PRIOR_WT:    m_pw = val[15:0];
            REG_NEW_WT:      m_nw = val[15:0];
            default: ;
        endcase
    endtask

    // Junk in the upper byte of 16-bit registers must be ignored
    task automatic write_all(int cx, int cy, int cs_, int co, int si, int pw, int nw);
        write_reg(REG_CENTER_X, cx[23:0]);
        write_reg(REG_CENTER_Y, cy[23:0]);
        write_reg(REG_COS_HEADING, {8'($urandom), co[15:0]});
        write_reg(REG_SIN_HEADING, {8'($urandom), si[15:0]});
        write_reg(REG_CELL_SIZE, {8'($urandom), cs_[15:0]});
        write_reg(REG_PRIOR_WT, {8'($urandom), pw[15:0]});
        write_reg(REG_NEW_WT, {8'($urandom), nw[15:0]});
        write_reg(REG_UNUSED, 24'($urandom));
    endtask

    // Wait for all results, then let the block settle before touching registers
    task automatic drain;
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Send one word in bursts with random gaps; predict on acceptance
    task automatic send_cell(logic [6:0] c, logic [6:0] r, logic [15:0] p,
                             logic typed, fusion_t want);
        bit taken;
        fusion_t f;
        if (burst_left == 0) begin
            @(posedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        @(posedge clk);
        in_valid <= 1'b1;
        cell_col <= c;
        cell_row <= r;
        cell_prob <= p;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        f = fuse_cell(c, r, p);
        pending_updates.push_back(typed ? want : f);
        burst_left--;
        in_valid <= 1'b0;
    endtask

    // Result side: stall pattern rotates through no stalls, random stalls and a periodic pattern
    always @(posedge clk) begin
        cycles <= cycles + 1;
        case ((cycles >> 8) % 3)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 9) < 3);
            default: out_stall <= ((cycles % 17) < 6);
        endcase
        if (cycles > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Check each accepted result word against the oldest prediction
    always @(negedge clk) begin
        fusion_t e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_updates.size() == 0) begin
                $error("result word with nothing expected");
                errs++;
            end else begin
                e = pending_updates.pop_front();
                if (in_map !== e.in_map) begin
                    $error("in_map exp %0d got %0d", e.in_map, in_map);
                    errs++;
                end
                if (target_col !== e.tcol) begin
                    $error("target_col exp %0d got %0d", e.tcol, target_col);
                    errs++;
                end
                if (target_row !== e.trow) begin
                    $error("target_row exp %0d got %0d", e.trow, target_row);
                    errs++;
                end
                if (posterior !== e.post) begin
                    $error("posterior exp %0d got %0d", e.post, posterior);
                    errs++;
                end
            end
        end
    end

    initial begin
        int cs_, spread;
        logic [15:0] p;
        logic [6:0] c, r;
        for (int i = 0; i < GLOBAL_SZ * GLOBAL_SZ; i++)
            map_model[i] = GRID_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed cells at reset settings
        foreach (dir_tab[i])
            send_cell(dir_tab[i].col, dir_tab[i].row, dir_tab[i].prob,
                      dir_tab[i].typed, dir_tab[i].want);
        drain();

        // Setting phases: fixed corners first, then random headings
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: write_all(1280, 1280, 10, 16384, 0, 65535, 58982);
                1: write_all(1280, 1000, 10, 0, 16384, 32768, 65535);
                2: write_all(128, 128, 0, -16384, 0, 0, 0);
                3: write_all(8388607, -8388608, 65535, 11585, -11585, 49152, 65535);
                default: begin
                    cs_ = $urandom_range(1, 200);
                    spread = 64 * cs_;
                    write_all(128 * cs_ + $urandom_range(0, 2 * spread) - spread,
                              128 * cs_ + $urandom_range(0, 2 * spread) - spread,
                              cs_, $urandom_range(0, 32768) - 16384,
                              $urandom_range(0, 32768) - 16384,
                              $urandom_range(0, 65535), $urandom_range(0, 65535));
                end
            endcase
            for (int k = 0; k < 105; k++) begin
                // Half the words revisit a few cells so stored priors build up
                if ($urandom_range(0, 1)) begin
                    c = 7'd60 + 7'($urandom_range(0, 3));
                    r = 7'd62 + 7'($urandom_range(0, 1));
                end else begin
                    c = 7'($urandom);
                    r = 7'($urandom);
                end
                case ($urandom_range(0, 9))
                    0: p = 16'd0;
                    1: p = 16'hFFFF;
                    2: p = 16'd32768;
                    default: p = 16'($urandom);
                endcase
                send_cell(c, r, p, 1'b0, OFF_MAP);
            end
            drain();
        end

        if (errs == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
